FILE: hdl/text_component_box_filter_macros.svh
// Assertion macros for the text component box filter.
`ifndef TEXT_COMPONENT_BOX_FILTER_MACROS_SVH
`define TEXT_COMPONENT_BOX_FILTER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TCBF_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define TCBF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/tcbf_pkg.sv
// Shared types and constants of the text component box filter.
package tcbf_pkg;
    localparam int MaxBoxes  = 64;
    localparam int CoordBits = 12;
    localparam int IdxBits   = $clog2(MaxBoxes);
    localparam int CntBits   = $clog2(MaxBoxes + 1);
    localparam int AreaBits  = 24;
    localparam int AddrBits  = 1;

    localparam logic [AddrBits-1:0] RegMinArea = 1'b0;
    localparam logic [AreaBits-1:0] MinAreaReset = 24'd20;

    typedef enum logic [1:0] {
        REASON_KEPT     = 2'd0,
        REASON_SHAPE    = 2'd1,
        REASON_NO_NEIGH = 2'd2,
        REASON_OVERFLOW = 2'd3
    } t_reason;

    typedef struct packed {
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_w;
        logic [11:0] box_h;
        logic        last_box;
    } t_in_beat;

    typedef struct packed {
        logic [5:0] box_index;
        logic       keep;
        logic [1:0] reason;
        logic       last_result;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SHAPE,
        ST_RD_I,
        ST_RD_J,
        ST_CMP,
        ST_EMIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic           load;      // capture input beat
        logic           shape_go;  // evaluate shape test of captured beat
        logic           rd_i;      // read box i
        logic           rd_j;      // read box j
        logic           cmp;       // compare i and j
        logic           emit;      // drive result
        logic [IdxBits-1:0] idx_i;
        logic [IdxBits-1:0] idx_j;
    } t_ctl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic shape_done;
        logic shape_bad_i;   // box i rejected by shape pass
        logic shape_bad_j;
        logic match;         // pair qualifies
    } t_dp_stat;
endpackage

FILE: hdl/tcbf_div.sv
// Restoring divider, one quotient bit per cycle, for the shape ratio test.
module tcbf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [15:0] i_num,
    input  logic [11:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [15:0] r_quo, n_quo;
    logic [12:0] r_rem, n_rem;
    logic [11:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done;
    logic [12:0] w_try;

    // Load the operands on go, else shift in one numerator bit and try a subtract.
    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        w_try = {r_rem[11:0], r_quo[15]};
        if (i_go) begin
            n_quo = i_num; n_rem = '0; n_cnt = 5'd16; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_quo = {r_quo[14:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_quo = {r_quo[14:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
            r_done <= r_busy && (r_cnt == 5'd1);
        end
        r_quo <= n_quo; r_rem <= n_rem;
        if (i_go) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: hdl/tcbf_datapath.sv
// Box store, shape test and pairwise neighbor test.
module tcbf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcbf_pkg::t_in_beat  i_beat,
    input  logic [23:0]         i_min_area,
    input  tcbf_pkg::t_ctl_cmd  i_cmd,
    output tcbf_pkg::t_dp_stat  o_stat
);
    import tcbf_pkg::*;

    logic [47:0] r_mem [MaxBoxes];
    logic        r_bad [MaxBoxes];
    logic [47:0] r_rd;
    logic        r_rd_bad;
    logic [11:0] r_xi, r_yi, r_wi, r_hi, r_w, r_h;
    logic        r_bad_i, r_bad_j;
    logic [IdxBits-1:0] r_wr_idx;
    logic        r_area_bad, r_div_go;
    logic [11:0] r_xj, r_yj, r_wj, r_hj;
    logic        r_match, r_rd_j_d, r_cmp_d;
    logic        r_sh_done;
    logic        w_div_done;
    logic [15:0] w_quo;
    logic        w_bad;
    logic [12:0] w_cxi, w_cyi, w_cxj, w_cyj, w_dx, w_dy;
    logic [11:0] w_mw, w_mh;
    logic [13:0] w_h2i, w_h4j;
    logic        w_rat;

    // Ratio 10w/h for the shape test.
    tcbf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  ({r_w, 3'b000} + {3'b000, r_w, 1'b0}),
        .i_den  (r_h),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    assign w_bad = (r_h == '0) || (w_quo > 16'd20) || (w_quo < 16'd1) || r_area_bad;

    // Capture beat, compute area, launch ratio, write store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0; r_sh_done <= 1'b0;
        end else begin
            r_div_go  <= i_cmd.shape_go;
            r_sh_done <= w_div_done;
        end
        if (i_cmd.load) begin
            r_w <= i_beat.box_w; r_h <= i_beat.box_h;
            r_wr_idx <= i_cmd.idx_i;
            r_mem[i_cmd.idx_i] <= {i_beat.box_x, i_beat.box_y, i_beat.box_w, i_beat.box_h};
        end
        if (i_cmd.shape_go)
            r_area_bad <= ({12'd0, r_w} * {12'd0, r_h}) < i_min_area;
        if (w_div_done) r_bad[r_wr_idx] <= w_bad;
        // Registered read port.
        if (i_cmd.rd_i || i_cmd.rd_j) begin
            r_rd     <= r_mem[i_cmd.rd_i ? i_cmd.idx_i : i_cmd.idx_j];
            r_rd_bad <= r_bad[i_cmd.rd_i ? i_cmd.idx_i : i_cmd.idx_j];
        end
    end

    // Latch box i or box j from the read port, and register the pair compare.
    logic r_rd_i_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_i_d <= 1'b0; r_rd_j_d <= 1'b0; r_cmp_d <= 1'b0;
        end else begin
            r_rd_i_d <= i_cmd.rd_i; r_rd_j_d <= i_cmd.rd_j; r_cmp_d <= i_cmd.cmp;
        end
        if (r_rd_i_d) begin
            {r_xi, r_yi, r_wi, r_hi} <= r_rd; r_bad_i <= r_rd_bad;
        end
        if (r_rd_j_d) begin
            {r_xj, r_yj, r_wj, r_hj} <= r_rd; r_bad_j <= r_rd_bad;
        end
        if (i_cmd.cmp) r_match <= w_rat && (w_dx <= {w_mw, 1'b0})
                                 && ({w_dy[11:0], 1'b0} <= {1'b0, w_mh}) && (w_dy[12] == 1'b0);
    end

    // 1 <= floor(2hi/hj) <= 4  <=>  hj <= 2hi < 5hj.
    assign w_h2i = {1'b0, r_hi, 1'b0};
    assign w_h4j = {r_hj, 2'b00};
    assign w_rat = ({2'b00, r_hj} <= w_h2i) && ({1'b0, w_h2i} < {1'b0, w_h4j} + {3'b000, r_hj});
    assign w_cxi = {1'b0, r_xi} + {2'b00, r_wi[11:1]};
    assign w_cyi = {1'b0, r_yi} + {2'b00, r_hi[11:1]};
    assign w_cxj = {1'b0, r_xj} + {2'b00, r_wj[11:1]};
    assign w_cyj = {1'b0, r_yj} + {2'b00, r_hj[11:1]};
    assign w_dx  = (w_cxi > w_cxj) ? w_cxi - w_cxj : w_cxj - w_cxi;
    assign w_dy  = (w_cyi > w_cyj) ? w_cyi - w_cyj : w_cyj - w_cyi;
    assign w_mw  = (r_wi > r_wj) ? r_wi : r_wj;
    assign w_mh  = (r_hi > r_hj) ? r_hi : r_hj;

    assign o_stat.shape_done  = r_sh_done;
    assign o_stat.shape_bad_i = r_bad_i;
    assign o_stat.shape_bad_j = r_bad_j;
    assign o_stat.match       = r_match & r_cmp_d;
endmodule

FILE: hdl/tcbf_ctrl.sv
// Sequencer for loading, shape test, pair scan and result emission.
module tcbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_last,
    input  tcbf_pkg::t_dp_stat  i_stat,
    output tcbf_pkg::t_ctl_cmd  o_cmd,
    output logic                o_busy,
    output tcbf_pkg::t_out_beat o_res,
    output logic                o_res_vld
);
    import tcbf_pkg::*;

    t_state r_st, n_st;
    logic [CntBits-1:0] r_cnt, n_cnt;
    logic [IdxBits-1:0] r_i, n_i, r_j, n_j;
    logic r_ovf, n_ovf, r_last, n_last, r_found, n_found;
    logic [1:0] r_wait, n_wait;
    t_out_beat r_res, n_res;
    logic r_vld, n_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_vld <= 1'b0;
            r_i <= '0; r_j <= '0; r_last <= 1'b0; r_found <= 1'b0; r_wait <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovf <= n_ovf; r_vld <= n_vld;
            r_i <= n_i; r_j <= n_j; r_last <= n_last; r_found <= n_found;
            r_wait <= n_wait;
        end
        r_res <= n_res;
    end

    // Next state and commands.
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf; n_i = r_i; n_j = r_j;
        n_last = r_last; n_found = r_found; n_wait = r_wait;
        n_res = r_res; n_vld = 1'b0;
        o_cmd = '0;
        o_cmd.idx_i = r_i; o_cmd.idx_j = r_j;
        case (r_st)
            ST_LOAD: begin
                if (i_start) begin
                    n_last = i_last;
                    if (r_cnt < CntBits'(MaxBoxes)) begin
                        o_cmd.load = 1'b1;
                        o_cmd.idx_i = r_cnt[IdxBits-1:0];
                        n_cnt = r_cnt + 1'b1;
                        n_st = ST_SHAPE;
                        n_wait = 2'd0;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_last) begin
                            n_i = '0; n_st = ST_RD_I;
                        end
                    end
                end
            end
            ST_SHAPE: begin
                if (r_wait == 2'd0) begin
                    o_cmd.shape_go = 1'b1; n_wait = 2'd1;
                end else if (i_stat.shape_done) begin
                    if (r_last) begin
                        n_i = '0; n_st = ST_RD_I;
                    end else n_st = ST_LOAD;
                end
            end
            ST_RD_I: begin
                o_cmd.rd_i = 1'b1; n_j = '0; n_found = 1'b0;
                n_wait = 2'd0; n_st = ST_RD_J;
            end
            ST_RD_J: begin
                // Read j, then wait for i and j to settle in regs.
                if (r_wait == 2'd0) begin
                    o_cmd.rd_j = 1'b1; n_wait = 2'd1;
                end else if (r_wait == 2'd1) n_wait = 2'd2;
                else begin
                    n_st = ST_CMP; n_wait = 2'd0;
                end
            end
            ST_CMP: begin
                if (r_wait == 2'd0) begin
                    o_cmd.cmp = 1'b1; n_wait = 2'd1;
                end else begin
                    if (i_stat.match && !i_stat.shape_bad_j && (r_j != r_i))
                        n_found = 1'b1;
                    if ((i_stat.match && !i_stat.shape_bad_j && (r_j != r_i))
                        || ({1'b0, r_j} + 1'b1 == r_cnt) || r_ovf || i_stat.shape_bad_i)
                        n_st = ST_EMIT;
                    else begin
                        n_j = r_j + 1'b1; n_wait = 2'd0; n_st = ST_RD_J;
                    end
                end
            end
            ST_EMIT: begin
                n_vld = 1'b1;
                n_res.box_index = 6'(r_i);
                n_res.last_result = ({1'b0, r_i} + 1'b1 == r_cnt);
                if (r_ovf) n_res.reason = REASON_OVERFLOW;
                else if (i_stat.shape_bad_i) n_res.reason = REASON_SHAPE;
                else if (!r_found) n_res.reason = REASON_NO_NEIGH;
                else n_res.reason = REASON_KEPT;
                n_res.keep = !r_ovf && !i_stat.shape_bad_i && r_found;
                if ({1'b0, r_i} + 1'b1 == r_cnt) begin
                    n_st = ST_LOAD; n_cnt = '0; n_ovf = 1'b0;
                end else begin
                    n_i = r_i + 1'b1; n_st = ST_RD_I;
                end
            end
            default: n_st = ST_LOAD;
        endcase
    end

    assign o_busy    = (r_st != ST_LOAD);
    assign o_res     = r_res;
    assign o_res_vld = r_vld;
endmodule

FILE: hdl/text_component_box_filter.sv
// Top level of the text component box filter.
// Boxes load one per start beat; each accepted box holds busy high while its ratio is
// divided, and the next beat can be taken only once busy has dropped again.
// After the last box, each stored box i is compared against boxes j in order: box i is
// read, then each box j is read and compared in turn through the single read port of the
// box store, stopping at the first neighbor, and then the result for box i is emitted.
// Results come out on o_res_vld one cycle each and cannot be stalled; busy drops in the
// cycle the final result is on the ports. A start beat with no room left is dropped, and
// the set then reports overflow.
module text_component_box_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tcbf_pkg::t_in_beat  i_beat,
    output logic                o_res_vld,
    output tcbf_pkg::t_out_beat o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [tcbf_pkg::AddrBits+1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tcbf_pkg::*;
    `include "text_component_box_filter_macros.svh"

    logic [AreaBits-1:0] r_min_area;
    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_area <= MinAreaReset;
        else if (psel && penable && pwrite && paddr[AddrBits+1:2] == RegMinArea)
            r_min_area <= pwdata[AreaBits-1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr[AddrBits+1:2] == RegMinArea) ? {8'd0, r_min_area} : 32'd0;

    tcbf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last(i_beat.last_box),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy), .o_res(o_res), .o_res_vld(o_res_vld)
    );

    tcbf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_beat(i_beat), .i_min_area(r_min_area),
        .i_cmd(w_cmd), .o_stat(w_stat)
    );

    `TCBF_ASSERT_IMP(a_keep_reason, i_clk, i_rst_n, o_res_vld, o_res.keep == (o_res.reason == REASON_KEPT))
    `TCBF_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_res_vld && o_res.last_result, !busy)
    `TCBF_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, w_cmd.load, start && !busy)
    `TCBF_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_cmd.load, busy)
endmodule
